// ----- hdl/ufrb_pkg.sv -----
// Shared types and constants for the UART FIFO register block.
// No dependencies; imported by ufrb_fifo and uart_fifo_register_block_unit.
package ufrb_pkg;

    localparam int DEF_FIFO_DEPTH = 8;

    localparam logic [31:0] FULL_FLAG = 32'h8000_0000;

    // Watermark count field in txctrl / rxctrl
    localparam int WM_LSB = 16;
    localparam int WM_MSB = 18;

    typedef enum logic [1:0] {
        FUNC_READ     = 2'd0,
        FUNC_WRITE    = 2'd1,
        FUNC_BYTE_IN  = 2'd2,
        FUNC_BYTE_OUT = 2'd3
    } func_t;

    // Register word offsets
    localparam logic [2:0] REG_TXDATA = 3'd0;
    localparam logic [2:0] REG_RXDATA = 3'd1;
    localparam logic [2:0] REG_TXCTRL = 3'd2;
    localparam logic [2:0] REG_RXCTRL = 3'd3;
    localparam logic [2:0] REG_IE     = 3'd4;
    localparam logic [2:0] REG_IP     = 3'd5;
    localparam logic [2:0] REG_DIV    = 3'd6;

    // Pending / enable bit positions
    localparam int TXWM_BIT = 0;
    localparam int RXWM_BIT = 1;

    typedef struct packed {
        func_t       func;
        logic [2:0]  reg_offset;
        logic [31:0] write_value;
        logic [7:0]  incoming_byte;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        byte_accepted;
        logic [7:0]  outgoing_byte;
        logic        outgoing_valid;
        logic        irq_level;
    } rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

endpackage

// ----- hdl/ufrb_cell.sv -----
// One byte cell of the shifting FIFO chain.
// Depends on nothing; instantiated by ufrb_fifo.
module ufrb_cell
(
    input  logic       clk,
    input  logic       load,
    input  logic       shift,
    input  logic [7:0] load_in,
    input  logic [7:0] shift_in,
    output logic [7:0] q
);

    logic [7:0] data_reg;

    // Payload only, no reset; load and shift never coincide
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_in;
        end
        else if (shift)
        begin
            data_reg <= shift_in;
        end
    end

    assign q = data_reg;

endmodule

// ----- hdl/ufrb_fifo.sv -----
// Byte FIFO built as a chain of ufrb_cell; cell 0 is the head.
// Depends on ufrb_pkg and ufrb_cell.
module ufrb_fifo
    import ufrb_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
    parameter int LVL_W      = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  fifo_ctl_t        ctl,
    input  logic [7:0]       push_data,
    output logic [7:0]       head,
    output logic [LVL_W-1:0] level,
    output logic [LVL_W-1:0] level_next,
    output logic             full,
    output logic             empty
);

    logic [LVL_W-1:0] level_reg;
    logic [7:0]       cell_q [FIFO_DEPTH];

    genvar i;
    generate
        for (i = 0; i < FIFO_DEPTH; i++)
        begin : g_cell
            logic [7:0] nb;
            if (i == FIFO_DEPTH - 1)
            begin : g_tail
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = cell_q[i+1];
            end

            // push lands in the first free cell; pop moves every cell one step on
            ufrb_cell u_cell
            (
                .clk      (clk),
                .load     (ctl.push && (level_reg == LVL_W'(i))),
                .shift    (ctl.pop),
                .load_in  (push_data),
                .shift_in (nb),
                .q        (cell_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        unique case ({ctl.push, ctl.pop})
            2'b10:   level_next = level_reg + LVL_W'(1);
            2'b01:   level_next = level_reg - LVL_W'(1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign head  = cell_q[0];
    assign level = level_reg;
    assign full  = (level_reg == LVL_W'(FIFO_DEPTH));
    assign empty = (level_reg == '0);

endmodule

// ----- hdl/uart_fifo_register_block_unit.sv -----
// UART register front end: bus register file plus transmit and receive byte FIFOs.
// The result word is registered and appears in the cycle after its request word is taken.
// Throughput: one word per cycle; the only stage is the result register, and a
// word is taken whenever that register is empty or being drained this cycle.
// Reset (rst_n low, asynchronous): both FIFOs empty, all control registers zero,
// no result pending. FIFO cell contents are not reset.
module uart_fifo_register_block_unit
    import ufrb_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    // Handshake: a new word goes in whenever the result slot can take it
    logic accept;

    // Control registers
    logic [31:0] txc_reg, txc_next;
    logic [31:0] rxc_reg, rxc_next;
    logic [1:0]  ie_reg,  ie_next;
    logic [31:0] div_reg, div_next;

    // Result register
    logic rsp_valid_reg;
    rsp_t rsp_reg, rsp_next;

    // FIFO side
    fifo_ctl_t        tx_ctl, rx_ctl;
    logic [7:0]       tx_head, rx_head;
    logic [LVL_W-1:0] tx_lvl, tx_lvl_next, rx_lvl, rx_lvl_next;
    logic             tx_full, tx_empty, rx_full, rx_empty;

    logic       is_rd, is_wr;
    logic [1:0] pend_now, pend_after;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign is_rd = accept && (req.func == FUNC_READ);
    assign is_wr = accept && (req.func == FUNC_WRITE);

    // Only one FIFO operation per word, so push and pop never meet
    assign tx_ctl.push = is_wr && (req.reg_offset == REG_TXDATA) && !tx_full;
    assign tx_ctl.pop  = accept && (req.func == FUNC_BYTE_OUT) && !tx_empty;
    assign rx_ctl.push = accept && (req.func == FUNC_BYTE_IN) && !rx_full;
    assign rx_ctl.pop  = is_rd && (req.reg_offset == REG_RXDATA) && !rx_empty;

    ufrb_fifo #(.FIFO_DEPTH(FIFO_DEPTH), .LVL_W(LVL_W)) u_tx_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tx_ctl),
        .push_data  (req.write_value[7:0]),
        .head       (tx_head),
        .level      (tx_lvl),
        .level_next (tx_lvl_next),
        .full       (tx_full),
        .empty      (tx_empty)
    );

    ufrb_fifo #(.FIFO_DEPTH(FIFO_DEPTH), .LVL_W(LVL_W)) u_rx_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rx_ctl),
        .push_data  (req.incoming_byte),
        .head       (rx_head),
        .level      (rx_lvl),
        .level_next (rx_lvl_next),
        .full       (rx_full),
        .empty      (rx_empty)
    );

    // Register writes
    always_comb
    begin
        txc_next = txc_reg;
        rxc_next = rxc_reg;
        ie_next  = ie_reg;
        div_next = div_reg;
        if (is_wr)
        begin
            // txdata is handled by the FIFO; rxdata, ip and bad offsets are ignored
            case (req.reg_offset)
                REG_TXCTRL: txc_next = req.write_value;
                REG_RXCTRL: rxc_next = req.write_value;
                REG_IE:     ie_next  = req.write_value[1:0];
                REG_DIV:    div_next = req.write_value;
                default:    ;
            endcase
        end
    end

    // Watermarks: tx below its count, rx above its count.
    // pend_now serves an ip read, pend_after drives the interrupt level.
    always_comb
    begin
        pend_now[TXWM_BIT]   = 32'(tx_lvl) < 32'(txc_reg[WM_MSB:WM_LSB]);
        pend_now[RXWM_BIT]   = 32'(rx_lvl) > 32'(rxc_reg[WM_MSB:WM_LSB]);
        pend_after[TXWM_BIT] = 32'(tx_lvl_next) < 32'(txc_next[WM_MSB:WM_LSB]);
        pend_after[RXWM_BIT] = 32'(rx_lvl_next) > 32'(rxc_next[WM_MSB:WM_LSB]);
    end

    // Result word
    always_comb
    begin
        rsp_next                = '0;
        rsp_next.byte_accepted  = rx_ctl.push;
        rsp_next.outgoing_valid = tx_ctl.pop;
        rsp_next.outgoing_byte  = tx_ctl.pop ? tx_head : 8'd0;
        rsp_next.irq_level      = |(pend_after & ie_next);
        if (is_rd)
        begin
            case (req.reg_offset)
                REG_TXDATA: rsp_next.read_value = tx_full ? FULL_FLAG : 32'd0;
                REG_RXDATA: rsp_next.read_value = rx_empty ? FULL_FLAG : {24'd0, rx_head};
                REG_TXCTRL: rsp_next.read_value = txc_reg;
                REG_RXCTRL: rsp_next.read_value = rxc_reg;
                REG_IE:     rsp_next.read_value = {30'd0, ie_reg};
                REG_IP:     rsp_next.read_value = {30'd0, pend_now};
                REG_DIV:    rsp_next.read_value = div_reg;
                default:    rsp_next.read_value = 32'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txc_reg       <= '0;
            rxc_reg       <= '0;
            ie_reg        <= '0;
            div_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            txc_reg <= txc_next;
            rxc_reg <= rxc_next;
            ie_reg  <= ie_next;
            div_reg <= div_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every taken word yields a result in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("result missing after accepted word");

    // A held result must block the input side
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> !accept)
        else $error("word accepted over a stalled result");

    // Across both FIFOs, at most one push or pop happens in one cycle
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({tx_ctl.push, tx_ctl.pop, rx_ctl.push, rx_ctl.pop}) <= 1)
        else $error("more than one FIFO operation for one word");

    // Fill levels stay within depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(tx_lvl) <= 32'(FIFO_DEPTH)) && (32'(rx_lvl) <= 32'(FIFO_DEPTH)))
        else $error("FIFO level beyond depth");

endmodule

// ----- tb/sv/uart_fifo_register_block_unit_checker.sv -----
`timescale 1ns / 1ps
// Checker for the UART FIFO register block: watches both channels, predicts each result word.
// Depends on ufrb_pkg for the word types, function codes and register offsets.
module uart_fifo_register_block_unit_checker
    import ufrb_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    // Predicted register file and FIFOs
    logic [7:0]  tx_mem [FIFO_DEPTH];
    logic [7:0]  rx_mem [FIFO_DEPTH];
    int unsigned tx_rd;
    int unsigned tx_cnt;
    int unsigned rx_rd;
    int unsigned rx_cnt;
    logic [31:0] tx_ctrl;
    logic [31:0] rx_ctrl;
    logic [1:0]  irq_en;
    logic [31:0] baud_div;

    rsp_t awaited_rsp[$];

    function automatic logic [1:0] watermarks();
        logic [1:0] wm;
        wm = '0;
        wm[TXWM_BIT] = tx_cnt < tx_ctrl[WM_MSB:WM_LSB];
        wm[RXWM_BIT] = rx_cnt > rx_ctrl[WM_MSB:WM_LSB];
        return wm;
    endfunction

    // Applies one request word to the predicted state, returns its result word
    function automatic rsp_t predict_response(req_t w);
        rsp_t r;
        r = '0;
        case (w.func)
            FUNC_READ:
            begin
                case (w.reg_offset)
                    REG_TXDATA: r.read_value = (tx_cnt >= FIFO_DEPTH) ? FULL_FLAG : '0;
                    REG_RXDATA:
                    begin
                        if (rx_cnt == 0)
                        begin
                            r.read_value = FULL_FLAG;
                        end
                        else
                        begin
                            r.read_value = {24'b0, rx_mem[rx_rd]};
                            rx_rd = (rx_rd + 1) % FIFO_DEPTH;
                            rx_cnt--;
                        end
                    end
                    REG_TXCTRL: r.read_value = tx_ctrl;
                    REG_RXCTRL: r.read_value = rx_ctrl;
                    REG_IE:     r.read_value = {30'b0, irq_en};
                    REG_IP:     r.read_value = {30'b0, watermarks()};
                    REG_DIV:    r.read_value = baud_div;
                    default:    r.read_value = '0;
                endcase
            end
            FUNC_WRITE:
            begin
                case (w.reg_offset)
                    REG_TXDATA:
                    begin
                        if (tx_cnt < FIFO_DEPTH)
                        begin
                            tx_mem[(tx_rd + tx_cnt) % FIFO_DEPTH] = w.write_value[7:0];
                            tx_cnt++;
                        end
                    end
                    REG_TXCTRL: tx_ctrl  = w.write_value;
                    REG_RXCTRL: rx_ctrl  = w.write_value;
                    REG_IE:     irq_en   = w.write_value[1:0];
                    REG_DIV:    baud_div = w.write_value;
                    default: ;
                endcase
            end
            FUNC_BYTE_IN:
            begin
                if (rx_cnt < FIFO_DEPTH)
                begin
                    rx_mem[(rx_rd + rx_cnt) % FIFO_DEPTH] = w.incoming_byte;
                    rx_cnt++;
                    r.byte_accepted = 1'b1;
                end
            end
            default:
            begin
                if (tx_cnt > 0)
                begin
                    r.outgoing_byte  = tx_mem[tx_rd];
                    r.outgoing_valid = 1'b1;
                    tx_rd = (tx_rd + 1) % FIFO_DEPTH;
                    tx_cnt--;
                end
            end
        endcase
        r.irq_level = |(watermarks() & irq_en);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endtask

    // Sampled mid-cycle: both sides change only at the rising edge, so what is
    // seen here is what the next rising edge takes.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_rd       = 0;
            tx_cnt      = 0;
            rx_rd       = 0;
            rx_cnt      = 0;
            tx_ctrl     = '0;
            rx_ctrl     = '0;
            irq_en      = '0;
            baud_div    = '0;
            mismatches  = 0;
            awaited_rsp.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("result word 0x%h with none outstanding", rsp);
                    mismatches++;
                end
                else
                begin
                    rsp_t want;
                    want = awaited_rsp.pop_front();
                    check_field("read_value",     want.read_value,     rsp.read_value);
                    check_field("byte_accepted",  want.byte_accepted,  rsp.byte_accepted);
                    check_field("outgoing_byte",  want.outgoing_byte,  rsp.outgoing_byte);
                    check_field("outgoing_valid", want.outgoing_valid, rsp.outgoing_valid);
                    check_field("irq_level",      want.irq_level,      rsp.irq_level);
                end
            end
            if (req_valid && !req_stall)
            begin
                awaited_rsp.push_back(predict_response(req));
            end
        end
        outstanding = awaited_rsp.size();
    end

endmodule

// ----- tb/sv/uart_fifo_register_block_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the UART FIFO register block testbench: clock, reset, request and result traffic.
// Depends on ufrb_pkg, the block and uart_fifo_register_block_unit_checker.
module uart_fifo_register_block_unit_tb;
    import ufrb_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;   // unmapped offset
    localparam int RANDOM_WORDS = 1750;
    localparam int QUIET_WORDS  = 150;        // tail of the run with no idling
    localparam int PHASE_LEN    = 40;
    localparam int PRESSURE_AT  = 600;
    localparam int HOLD_CYCLES  = 120;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int mismatches;
    int outstanding;

    // Shared between the stimulus and the result-side process
    bit quiet;
    bit pressure_req;

    uart_fifo_register_block_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    uart_fifo_register_block_unit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop, well beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic req_t make_word(func_t f, logic [2:0] off, logic [31:0] val,
                                       logic [7:0] b);
        req_t w;
        w.func          = f;
        w.reg_offset    = off;
        w.write_value   = val;
        w.incoming_byte = b;
        return w;
    endfunction

    // Phases steer towards one FIFO action so both FIFOs are driven to full and
    // to empty repeatedly; the rest is random traffic and watermark/enable writes.
    function automatic req_t random_word(int phase);
        req_t w;
        int   pick;
        w = make_word(func_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom,
                      8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            case (phase)
                0:
                begin
                    w.func       = FUNC_WRITE;
                    w.reg_offset = REG_TXDATA;
                end
                1: w.func = FUNC_BYTE_OUT;
                2: w.func = FUNC_BYTE_IN;
                3:
                begin
                    w.func       = FUNC_READ;
                    w.reg_offset = REG_RXDATA;
                end
                default: ;
            endcase
        end
        else if (pick == 6)
        begin
            w.func       = FUNC_WRITE;
            w.reg_offset = 3'($urandom_range(REG_TXCTRL, REG_IE));
        end
        return w;
    endfunction

    // Offers one word; returns at the rising edge that takes it.
    task automatic issue_word(req_t w);
        logic stalled;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
        begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    // Result side: random stall bursts, one long hold-off on request, none at the end
    initial
    begin
        rsp_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (pressure_req)
            begin
                pressure_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        req_t w;
        int   counted;
        int   word_idx;
        int   phase;
        int   guard;

        quiet        = 1'b0;
        pressure_req = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty receive read, unmapped offset, transmit status read, ignored writes
        issue_word(make_word(FUNC_READ, REG_RXDATA, '0, '0));
        issue_word(make_word(FUNC_READ, REG_NONE, '0, '0));
        issue_word(make_word(FUNC_READ, REG_TXDATA, '0, '0));
        issue_word(make_word(FUNC_WRITE, REG_NONE, '1, '1));
        issue_word(make_word(FUNC_WRITE, REG_RXDATA, '1, '1));
        issue_word(make_word(FUNC_WRITE, REG_IP, '1, '1));
        // Both interrupts enabled, transmit watermark at 7, receive at 0
        issue_word(make_word(FUNC_WRITE, REG_IE, '1, '0));
        issue_word(make_word(FUNC_WRITE, REG_TXCTRL, '1, '0));
        issue_word(make_word(FUNC_WRITE, REG_RXCTRL, '0, '0));
        issue_word(make_word(FUNC_WRITE, REG_DIV, '1, '0));
        // Pull from an empty transmit FIFO
        issue_word(make_word(FUNC_BYTE_OUT, '0, '0, '0));
        // Fill the transmit FIFO; the ninth write is dropped
        for (int i = 0; i < 9; i++)
        begin
            issue_word(make_word(FUNC_WRITE, REG_TXDATA, (i % 2) ? '1 : '0, '0));
        end
        issue_word(make_word(FUNC_READ, REG_TXDATA, '0, '0));
        // Fill the receive FIFO; the ninth byte is refused
        for (int i = 0; i < 9; i++)
        begin
            issue_word(make_word(FUNC_BYTE_IN, '0, '0, (i % 2) ? 8'hFF : 8'h00));
        end
        issue_word(make_word(FUNC_READ, REG_IP, '0, '0));

        // Random part; writes the block ignores are not counted
        counted  = 0;
        word_idx = 0;
        phase    = 4;
        while (counted < RANDOM_WORDS)
        begin
            if (word_idx % PHASE_LEN == 0)
            begin
                phase = $urandom_range(0, 4);
            end
            if (word_idx == PRESSURE_AT)
            begin
                pressure_req = 1'b1;
            end
            if (counted >= RANDOM_WORDS - QUIET_WORDS)
            begin
                quiet = 1'b1;
            end
            w = random_word(phase);
            issue_word(w);
            if (!(w.func == FUNC_WRITE && w.reg_offset inside {REG_RXDATA, REG_IP, REG_NONE}))
            begin
                counted++;
            end
            word_idx++;
        end
        req_valid <= 1'b0;

        // Drain, then watch for any stray result word
        guard = 0;
        while (outstanding != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ufrb_pkg.sv
hdl/ufrb_cell.sv
hdl/ufrb_fifo.sv
hdl/uart_fifo_register_block_unit.sv
tb/sv/uart_fifo_register_block_unit_checker.sv
tb/sv/uart_fifo_register_block_unit_tb.sv
